// ===== hdl/pcdm_pkg.sv =====
// ============================================================================
// pcdm_pkg
// Shared types and constants of the PWM capture duty meter.
// ============================================================================
package pcdm_pkg;

  // Field widths.
  localparam int unsigned CaptureWidth = 16;
  localparam int unsigned TotalWidth   = CaptureWidth + 1;
  localparam int unsigned DutyWidth    = 7;

  // Duty is expressed in whole percent.
  localparam int unsigned DutyScale    = 100;

  // Restoring divider: one quotient bit per cycle.
  localparam int unsigned DivSteps     = DutyWidth;
  localparam int unsigned StepWidth    = $clog2(DivSteps);
  localparam int unsigned NumWidth     = CaptureWidth + DutyWidth;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 update;    // Take a capture transaction.
    logic                 prepare;   // Form numerator and shifted divisor.
    logic                 div_step;  // Produce one quotient bit.
    logic                 load_out;  // Move the finished result to the output.
  } pcdm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // Output register holds a result that is not taken now.
  } pcdm_status_t;

endpackage

// ===== hdl/pwm_capture_duty_meter.sv =====
// ============================================================================
// pwm_capture_duty_meter
// PWM duty measurement from timer input-capture events.
// ============================================================================
// Each input transaction carries one 16-bit timer capture. Captures alternate
// between rising and falling edges, starting with a rising edge after reset;
// each produces exactly one result with the next edge to arm, the on, off
// and total periods, and the duty in truncated whole percent. A zero total
// period gives duty 0 with duty_valid low. One capture is processed at a
// time. The period registers update at the accepting edge, then follow the
// multiply step, the bit-serial restoring divider that forms the 7-bit duty
// and a step that loads the output register. The next capture is accepted
// once the result is loaded, even while the result still waits in the
// output register; only if the previous result has not been taken when the
// new one is ready does the block stall until it is.
// ============================================================================
module pwm_capture_duty_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: [15:0] capture_time
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [pcdm_pkg::InDataWidth-1:0]    s_axis_tdata_i,
  // tdata: [0] next_edge_falling, [16:1] on_period, [32:17] off_period,
  // [49:33] total_period, [56:50] duty_percent, [57] duty_valid, rest zero
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [pcdm_pkg::OutDataWidth-1:0]   m_axis_tdata_o
);

  pcdm_pkg::pcdm_cmd_t    cmd;
  pcdm_pkg::pcdm_status_t status;

  pcdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcdm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capture_time_i (s_axis_tdata_i[pcdm_pkg::CaptureWidth-1:0]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_data_o     (m_axis_tdata_o)
  );

endmodule

// ===== hdl/pcdm_ctrl.sv =====
// ============================================================================
// pcdm_ctrl
// Controller that sequences update, divide and output of one capture event.
// ============================================================================
module pcdm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pcdm_pkg::pcdm_status_t status_i,
  output pcdm_pkg::pcdm_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  localparam logic [pcdm_pkg::StepWidth-1:0] LastStep =
    pcdm_pkg::StepWidth'(pcdm_pkg::DivSteps - 1);

  logic [1:0]                    state_q, state_d;
  logic [pcdm_pkg::StepWidth-1:0] step_q, step_d;

  // Next-state and command logic.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.update = 1'b1;
          state_d      = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prepare = 1'b1;
        step_d        = '0;
        state_d       = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== hdl/pcdm_datapath.sv =====
// ============================================================================
// pcdm_datapath
// Period registers, duty multiplier, restoring divider and output register.
// ============================================================================
module pcdm_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [pcdm_pkg::CaptureWidth-1:0]     capture_time_i,
  input  pcdm_pkg::pcdm_cmd_t                   cmd_i,
  output pcdm_pkg::pcdm_status_t                status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pcdm_pkg::OutDataWidth-1:0]     out_data_o
);

  localparam int unsigned CW = pcdm_pkg::CaptureWidth;
  localparam int unsigned TW = pcdm_pkg::TotalWidth;
  localparam int unsigned DW = pcdm_pkg::DutyWidth;
  localparam int unsigned NW = pcdm_pkg::NumWidth;
  localparam int unsigned PadWidth = pcdm_pkg::OutDataWidth - (1 + 3 * CW + 1 + DW + 1);

  logic          awaiting_falling_q;
  logic [CW-1:0] prev_capture_q;
  logic [CW-1:0] high_time_q;
  logic [CW-1:0] low_time_q;
  logic [CW-1:0] delta;
  logic [TW-1:0] total;

  logic [NW-1:0] rem_q;
  logic [NW-1:0] div_q;
  logic [DW-1:0] quo_q;
  logic          rem_ge;

  logic                              out_valid_q;
  logic [pcdm_pkg::OutDataWidth-1:0] out_data_q;
  logic                              duty_valid;

  // Period difference wraps modulo the timer width.
  assign delta      = capture_time_i - prev_capture_q;
  assign total      = TW'(high_time_q) + TW'(low_time_q);
  assign duty_valid = (total != '0);
  assign rem_ge     = (rem_q >= div_q);

  // Measurement state, updated once per capture transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_falling_q <= 1'b0;
      prev_capture_q     <= '0;
      high_time_q        <= '0;
      low_time_q         <= '0;
    end else if (cmd_i.update) begin
      if (!awaiting_falling_q) begin
        low_time_q <= delta;
      end else begin
        high_time_q <= delta;
      end
      awaiting_falling_q <= ~awaiting_falling_q;
      prev_capture_q     <= capture_time_i;
    end
  end

  // Duty division: numerator on*100, divisor total aligned to the top
  // quotient bit, one compare and subtract per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prepare) begin
      rem_q <= NW'(high_time_q) * NW'(pcdm_pkg::DutyScale);
      div_q <= {total, {(NW - TW){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - div_q;
      end
      quo_q <= {quo_q[DW-2:0], rem_ge};
      div_q <= div_q >> 1;
    end
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {{PadWidth{1'b0}},
                     duty_valid,
                     duty_valid ? quo_q : {DW{1'b0}},
                     total,
                     low_time_q,
                     high_time_q,
                     awaiting_falling_q};
    end
  end

  assign status_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// ===== hdl/pcdm_checker.sv =====
// ============================================================================
// pcdm_checker
// Port-level checks of the PWM capture duty meter.
// ============================================================================
module pcdm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [pcdm_pkg::OutDataWidth-1:0] m_axis_tdata_o
);

  logic [15:0] on_p;
  logic [15:0] off_p;
  logic [16:0] total_p;
  logic [6:0]  duty_p;
  logic        dvalid_p;

  assign on_p     = m_axis_tdata_o[16:1];
  assign off_p    = m_axis_tdata_o[32:17];
  assign total_p  = m_axis_tdata_o[49:33];
  assign duty_p   = m_axis_tdata_o[56:50];
  assign dvalid_p = m_axis_tdata_o[57];

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before it was taken");

  // One capture at a time: no acceptance right after an acceptance.
  a_in_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("capture accepted while the previous one is in progress");

  // The total is the sum of the reported periods.
  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> total_p == 17'(on_p) + 17'(off_p))
    else $error("total period differs from on plus off");

  // The valid flag follows a nonzero total, and a zero total gives zero duty.
  a_duty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (dvalid_p == (total_p != '0)) && (dvalid_p || duty_p == '0))
    else $error("duty valid flag inconsistent with total period");

  // Duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> duty_p <= 7'(pcdm_pkg::DutyScale))
    else $error("duty above full scale");

endmodule

bind pwm_capture_duty_meter pcdm_checker u_pcdm_checker (.*);
